>>> rtl/core/esc_pkg.sv
// Shared types and constants for the ESC throttle and fault monitor.
// No dependencies; imported by every module of the block.
package esc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_OVER_VOLT  = 3'd0;
  localparam logic [2:0] CFG_UNDER_VOLT = 3'd1;
  localparam logic [2:0] CFG_CUR_OFFSET = 3'd2;
  localparam logic [2:0] CFG_OVER_CUR   = 3'd3;
  localparam logic [2:0] CFG_ARM_TICKS  = 3'd4;
  localparam logic [2:0] CFG_PROT_EN    = 3'd5;

  // request kinds
  localparam logic MODE_CAPTURE = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  // fault codes
  localparam logic [2:0] FLT_NONE       = 3'd0;
  localparam logic [2:0] FLT_OVER_VOLT  = 3'd1;
  localparam logic [2:0] FLT_UNDER_VOLT = 3'd2;
  localparam logic [2:0] FLT_OVER_CUR   = 3'd3;
  localparam logic [2:0] FLT_STALL      = 3'd4;
  localparam logic [2:0] FLT_PHASE      = 3'd5;

  // protect_enable bits
  localparam int PEN_VOLT  = 0;
  localparam int PEN_CUR   = 1;
  localparam int PEN_STALL = 2;
  localparam int PEN_PHASE = 3;

  // pulse width mapping (microseconds)
  localparam logic [15:0] PW_MIN       = 16'd960;
  localparam logic [15:0] PW_OFFSET    = 16'd900;
  localparam logic [15:0] PW_SAT       = 16'd1400;  // width - offset reaches the cap here
  localparam logic [8:0]  THR_LOW      = 9'd80;
  localparam logic [8:0]  THR_MAX      = 9'd500;

  // stall test
  localparam logic [8:0]  STALL_DUTY   = 9'd321;
  localparam logic [15:0] STALL_SPEED  = 16'd123;
  localparam int          STALL_NET    = 321;

  // reset values of the configuration registers and of the advance state
  localparam logic [11:0] RST_OVER_VOLT  = 12'd4095;
  localparam logic [11:0] RST_UNDER_VOLT = 12'd0;
  localparam logic [11:0] RST_CUR_OFFSET = 12'd0;
  localparam logic [11:0] RST_OVER_CUR   = 12'd2850;
  localparam logic [7:0]  RST_ARM_TICKS  = 8'd255;
  localparam logic [3:0]  RST_PROT_EN    = 4'd15;
  localparam logic [2:0]  RST_ADVANCE    = 3'd7;

  typedef struct packed {
    logic [11:0] over_volt;
    logic [11:0] under_volt;
    logic [11:0] cur_offset;
    logic [11:0] over_cur;
    logic [3:0]  prot_en;
  } prot_cfg_t;

  typedef struct packed {
    logic [8:0] throttle;
    logic [8:0] drive_duty;
    logic [2:0] advance_tenths;
    logic       armed;
    logic [2:0] fault_code;
    logic       drive_off;
  } status_t;

endpackage

>>> rtl/core/esc_pulse.sv
// Pulse width to throttle mapping and duty to commutation advance bands.
// Depends on esc_pkg.
module esc_pulse (
  input  logic [15:0] width,
  input  logic        armed,
  input  logic [8:0]  duty_cur,
  output logic [8:0]  throttle,
  output logic [8:0]  duty_new,
  output logic [2:0]  advance
);
  import esc_pkg::*;

  logic [15:0] diff;

  assign diff = width - PW_OFFSET;

  always_comb begin
    if (width < PW_MIN) begin
      throttle = THR_LOW;
    end else if (width > PW_SAT) begin
      throttle = THR_MAX;
    end else begin
      throttle = diff[8:0];
    end
  end

  assign duty_new = armed ? throttle : duty_cur;

  always_comb begin
    if (duty_new <= 9'd120) begin
      advance = 3'd7;
    end else if (duty_new <= 9'd130) begin
      advance = 3'd6;
    end else if (duty_new <= 9'd140) begin
      advance = 3'd5;
    end else if (duty_new <= 9'd150) begin
      advance = 3'd4;
    end else if (duty_new <= 9'd170) begin
      advance = 3'd3;
    end else begin
      advance = 3'd2;
    end
  end

endmodule

>>> rtl/core/esc_protect.sv
// Protection checks for one tick: voltage, overcurrent, stall, phase loss.
// Depends on esc_pkg; gives the first fault found in priority order.
module esc_protect #(
  parameter int ADC_BITS = 12
) (
  input  esc_pkg::prot_cfg_t  cfg,
  input  logic [ADC_BITS-1:0] bus_voltage,
  input  logic [ADC_BITS-1:0] current_raw,
  input  logic [15:0]         motor_speed,
  input  logic [8:0]          duty,
  input  logic signed [12:0]  phase_a,
  input  logic signed [12:0]  phase_b,
  input  logic signed [12:0]  phase_c,
  output logic [2:0]          fault
);
  import esc_pkg::*;

  localparam int AW = (ADC_BITS > 12) ? ADC_BITS : 12;

  logic [AW-1:0]        bus_x;
  logic [AW-1:0]        cur_x;
  logic signed [AW:0]   net;
  logic signed [12:0]   half_a;
  logic signed [12:0]   half_b;
  logic signed [12:0]   half_c;
  logic                 over_v;
  logic                 under_v;
  logic                 over_c;
  logic                 stall;
  logic                 phase_loss;

  // halving that truncates toward zero
  function automatic logic signed [12:0] half_tz(input logic signed [12:0] x);
    logic signed [13:0] s;
    s = {x[12], x} + {13'd0, x[12]};
    return s[13:1];
  endfunction

  assign bus_x = AW'(bus_voltage);
  assign cur_x = AW'(current_raw);
  assign net   = $signed({1'b0, cur_x}) - $signed({1'b0, AW'(cfg.cur_offset)});

  assign half_a = half_tz(phase_a);
  assign half_b = half_tz(phase_b);
  assign half_c = half_tz(phase_c);

  assign over_v  = cfg.prot_en[PEN_VOLT] && (bus_x > AW'(cfg.over_volt));
  assign under_v = cfg.prot_en[PEN_VOLT] && (bus_x < AW'(cfg.under_volt));
  assign over_c  = cfg.prot_en[PEN_CUR] && (cur_x > AW'(cfg.over_cur));
  assign stall   = cfg.prot_en[PEN_STALL] && (duty > STALL_DUTY) &&
                   (motor_speed < STALL_SPEED) && (net > (AW+1)'(STALL_NET));
  assign phase_loss = cfg.prot_en[PEN_PHASE] &&
                      ((phase_a < half_b) || (phase_a < half_c) ||
                       (phase_b < half_a) || (phase_b < half_c) ||
                       (phase_c < half_b) || (phase_c < half_a));

  always_comb begin
    if (over_v) begin
      fault = FLT_OVER_VOLT;
    end else if (under_v) begin
      fault = FLT_UNDER_VOLT;
    end else if (over_c) begin
      fault = FLT_OVER_CUR;
    end else if (stall) begin
      fault = FLT_STALL;
    end else if (phase_loss) begin
      fault = FLT_PHASE;
    end else begin
      fault = FLT_NONE;
    end
  end

endmodule

>>> rtl/core/esc_obuf.sv
// Two-entry result buffer between the processing stage and the out channel.
// Depends on esc_pkg for the status type.
module esc_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  esc_pkg::status_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output esc_pkg::status_t head
);
  import esc_pkg::*;

  status_t    mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/core/esc_throttle_pulse_and_fault_monitor_core.sv
// Top level of the ESC throttle decoder and fault monitor.
// Depends on esc_pkg, esc_pulse, esc_protect and esc_obuf.
//
// Use: each request on the in_ channel is either a capture edge (in_mode 0)
// or a control tick (in_mode 1). Every request yields exactly one status
// result on the out_ channel, in order. A request is taken when in_valid is
// high and in_stall low; a result is taken when out_valid is high and
// out_stall low.
// Path: a taken request is held in the input register and is decoded as it
// moves into the result buffer, whose head shows on out_.
// Throughput: one request per cycle; the input register and a two-entry
// result buffer let a new request enter while a result waits. in_stall rises
// only when the buffer is full and the receiver holds out_stall.
// Configuration: cfg_we writes register cfg_index with cfg_data; unknown
// indexes are ignored. Write only while no request is in flight.
// Reset (rst_n low, synchronous) restores config and state registers to
// defaults, disarms the block, clears any latched fault, empties the buffer.
// Once a fault latches, status freezes until reset and drive_off stays high.
module esc_throttle_pulse_and_fault_monitor_core #(
  parameter int ADC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [11:0]         cfg_data,
  // requests
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [15:0]         in_capture_value,
  input  logic [ADC_BITS-1:0] in_bus_voltage,
  input  logic [ADC_BITS-1:0] in_current_raw,
  input  logic [15:0]         in_motor_speed,
  input  logic signed [12:0]  in_phase_a_current,
  input  logic signed [12:0]  in_phase_b_current,
  input  logic signed [12:0]  in_phase_c_current,
  // results
  output logic                out_valid,
  input  logic                out_stall,
  output logic [8:0]          out_throttle,
  output logic [8:0]          out_drive_duty,
  output logic [2:0]          out_advance_tenths,
  output logic                out_armed,
  output logic [2:0]          out_fault_code,
  output logic                out_drive_off
);
  import esc_pkg::*;

  // configuration registers
  prot_cfg_t cfg_r;
  logic [7:0] arm_ticks_r;

  // input register
  logic                s1_valid_r;
  logic                s1_valid_nxt;
  logic                s1_mode_r;
  logic [15:0]         s1_width_r;
  logic [ADC_BITS-1:0] s1_bus_r;
  logic [ADC_BITS-1:0] s1_cur_r;
  logic [15:0]         s1_speed_r;
  logic signed [12:0]  s1_pa_r;
  logic signed [12:0]  s1_pb_r;
  logic signed [12:0]  s1_pc_r;

  // block state
  logic       awaiting_fall_r, awaiting_fall_nxt;
  logic       pending_r, pending_nxt;
  logic [7:0] arm_cnt_r, arm_cnt_nxt;
  logic       armed_r, armed_nxt;
  logic [8:0] throttle_r, throttle_nxt;
  logic [8:0] duty_r, duty_nxt;
  logic [2:0] advance_r, advance_nxt;
  logic [2:0] fault_r, fault_nxt;

  logic       in_take;
  logic       s1_move;
  logic       s1_fire;
  logic       buf_full;
  logic       buf_pop;
  logic [8:0] pw_throttle;
  logic [8:0] pw_duty;
  logic [2:0] pw_advance;
  logic [2:0] tick_fault;
  logic [7:0] cnt_inc;
  status_t    res;
  status_t    head;

  // ---------------------------------------------------------------------
  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.over_volt  <= RST_OVER_VOLT;
      cfg_r.under_volt <= RST_UNDER_VOLT;
      cfg_r.cur_offset <= RST_CUR_OFFSET;
      cfg_r.over_cur   <= RST_OVER_CUR;
      cfg_r.prot_en    <= RST_PROT_EN;
      arm_ticks_r      <= RST_ARM_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OVER_VOLT:  cfg_r.over_volt  <= cfg_data;
        CFG_UNDER_VOLT: cfg_r.under_volt <= cfg_data;
        CFG_CUR_OFFSET: cfg_r.cur_offset <= cfg_data;
        CFG_OVER_CUR:   cfg_r.over_cur   <= cfg_data;
        CFG_ARM_TICKS:  arm_ticks_r      <= cfg_data[7:0];
        CFG_PROT_EN:    cfg_r.prot_en    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // handshake: the input register drains into the buffer unless it is full
  // and nothing leaves it this cycle
  assign buf_pop  = out_valid && !out_stall;
  assign s1_move  = !buf_full || buf_pop;
  assign s1_fire  = s1_valid_r && s1_move;
  assign in_stall = s1_valid_r && !s1_move;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt = in_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r  <= in_mode;
      s1_width_r <= in_capture_value;
      s1_bus_r   <= in_bus_voltage;
      s1_cur_r   <= in_current_raw;
      s1_speed_r <= in_motor_speed;
      s1_pa_r    <= in_phase_a_current;
      s1_pb_r    <= in_phase_b_current;
      s1_pc_r    <= in_phase_c_current;
    end
  end

  // ---------------------------------------------------------------------
  // decode
  esc_pulse u_pulse (
    .width    (s1_width_r),
    .armed    (armed_r),
    .duty_cur (duty_r),
    .throttle (pw_throttle),
    .duty_new (pw_duty),
    .advance  (pw_advance)
  );

  esc_protect #(
    .ADC_BITS (ADC_BITS)
  ) u_protect (
    .cfg         (cfg_r),
    .bus_voltage (s1_bus_r),
    .current_raw (s1_cur_r),
    .motor_speed (s1_speed_r),
    .duty        (duty_r),
    .phase_a     (s1_pa_r),
    .phase_b     (s1_pb_r),
    .phase_c     (s1_pc_r),
    .fault       (tick_fault)
  );

  assign cnt_inc = pending_r ? (arm_cnt_r + 8'd1) : arm_cnt_r;

  always_comb begin
    awaiting_fall_nxt = awaiting_fall_r;
    pending_nxt       = pending_r;
    arm_cnt_nxt       = arm_cnt_r;
    armed_nxt         = armed_r;
    throttle_nxt      = throttle_r;
    duty_nxt          = duty_r;
    advance_nxt       = advance_r;
    fault_nxt         = fault_r;
    // a latched fault freezes everything
    if (fault_r == FLT_NONE) begin
      if (s1_mode_r == MODE_CAPTURE) begin
        if (!awaiting_fall_r) begin
          awaiting_fall_nxt = 1'b1;
        end else begin
          awaiting_fall_nxt = 1'b0;
          throttle_nxt      = pw_throttle;
          duty_nxt          = pw_duty;
          advance_nxt       = pw_advance;
          if (!armed_r) begin
            pending_nxt = 1'b1;
          end
        end
      end else begin
        pending_nxt = 1'b0;
        if (cnt_inc >= arm_ticks_r) begin
          arm_cnt_nxt = 8'd0;
          armed_nxt   = 1'b1;
        end else begin
          arm_cnt_nxt = cnt_inc;
        end
        fault_nxt = tick_fault;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_fall_r <= 1'b0;
      pending_r       <= 1'b0;
      arm_cnt_r       <= 8'd0;
      armed_r         <= 1'b0;
      throttle_r      <= 9'd0;
      duty_r          <= 9'd0;
      advance_r       <= RST_ADVANCE;
      fault_r         <= FLT_NONE;
    end else if (s1_fire) begin
      awaiting_fall_r <= awaiting_fall_nxt;
      pending_r       <= pending_nxt;
      arm_cnt_r       <= arm_cnt_nxt;
      armed_r         <= armed_nxt;
      throttle_r      <= throttle_nxt;
      duty_r          <= duty_nxt;
      advance_r       <= advance_nxt;
      fault_r         <= fault_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // result
  always_comb begin
    res.throttle       = throttle_nxt;
    res.drive_duty     = (fault_nxt != FLT_NONE) ? 9'd0 : duty_nxt;
    res.advance_tenths = advance_nxt;
    res.armed          = armed_nxt;
    res.fault_code     = fault_nxt;
    res.drive_off      = (fault_nxt != FLT_NONE);
  end

  esc_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_fire),
    .push_data (res),
    .pop       (buf_pop),
    .full      (buf_full),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_throttle       = head.throttle;
  assign out_drive_duty     = head.drive_duty;
  assign out_advance_tenths = head.advance_tenths;
  assign out_armed          = head.armed;
  assign out_fault_code     = head.fault_code;
  assign out_drive_off      = head.drive_off;

endmodule

>>> tb/sv/esc_status_tracker_pkg.sv
// Request type and status tracker for the ESC throttle and fault monitor bench.
// Depends on esc_pkg; imported by the bench top module.
package esc_tracker_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import esc_pkg::*;

  typedef struct {
    logic               mode;
    logic [15:0]        capture_value;
    logic [11:0]        bus_voltage;
    logic [11:0]        current_raw;
    logic [15:0]        motor_speed;
    logic signed [12:0] phase_a;
    logic signed [12:0] phase_b;
    logic signed [12:0] phase_c;
  } esc_req_t;

  // Tracks throttle, arming and fault state from accepted requests and holds
  // the status results still owed by the block.
  class esc_status_tracker;
    logic [11:0] over_volt  = RST_OVER_VOLT;
    logic [11:0] under_volt = RST_UNDER_VOLT;
    logic [11:0] cur_offset = RST_CUR_OFFSET;
    logic [11:0] over_cur   = RST_OVER_CUR;
    logic [7:0]  arm_ticks  = RST_ARM_TICKS;
    logic [3:0]  prot_en    = RST_PROT_EN;

    bit          awaiting_fall = 1'b0;
    bit          pulse_pending = 1'b0;
    logic [7:0]  arm_count     = 8'd0;
    bit          armed         = 1'b0;
    logic [8:0]  throttle      = 9'd0;
    logic [8:0]  duty          = 9'd0;
    logic [2:0]  advance       = RST_ADVANCE;
    logic [2:0]  fault         = FLT_NONE;

    status_t     owed_status[$];
    int unsigned mismatches = 0;

    function void write_reg(logic [2:0] idx, logic [11:0] data);
      case (idx)
        CFG_OVER_VOLT:  over_volt  = data;
        CFG_UNDER_VOLT: under_volt = data;
        CFG_CUR_OFFSET: cur_offset = data;
        CFG_OVER_CUR:   over_cur   = data;
        CFG_ARM_TICKS:  arm_ticks  = data[7:0];
        CFG_PROT_EN:    prot_en    = data[3:0];
        default: ;
      endcase
    endfunction

    function logic [8:0] width_to_throttle(logic [15:0] w);
      logic [15:0] t;
      if (w < PW_MIN) return THR_LOW;
      if (w >= PW_SAT) return THR_MAX;  // covers the over-range clamp too
      t = w - PW_OFFSET;
      return t[8:0];
    endfunction

    function logic [2:0] advance_for(logic [8:0] d);
      if (d <= 9'd120) return 3'd7;
      if (d <= 9'd130) return 3'd6;
      if (d <= 9'd140) return 3'd5;
      if (d <= 9'd150) return 3'd4;
      if (d <= 9'd170) return 3'd3;
      return 3'd2;
    endfunction

    function bit half_under(int x, int y);
      return x < (y / 2);
    endfunction

    // first fault a tick would latch under the current limits and duty
    function logic [2:0] tick_fault(esc_req_t r);
      int net;
      int a;
      int b;
      int c;
      net = int'(r.current_raw) - int'(cur_offset);
      a = int'(r.phase_a);
      b = int'(r.phase_b);
      c = int'(r.phase_c);
      if (prot_en[PEN_VOLT] && r.bus_voltage > over_volt) return FLT_OVER_VOLT;
      if (prot_en[PEN_VOLT] && r.bus_voltage < under_volt) return FLT_UNDER_VOLT;
      if (prot_en[PEN_CUR] && r.current_raw > over_cur) return FLT_OVER_CUR;
      if (prot_en[PEN_STALL] && duty > STALL_DUTY && r.motor_speed < STALL_SPEED &&
          net > STALL_NET)
        return FLT_STALL;
      if (prot_en[PEN_PHASE] &&
          (half_under(a, b) || half_under(a, c) || half_under(b, a) ||
           half_under(b, c) || half_under(c, b) || half_under(c, a)))
        return FLT_PHASE;
      return FLT_NONE;
    endfunction

    function void take_request(esc_req_t r);
      status_t s;
      if (fault == FLT_NONE) begin
        if (r.mode == MODE_CAPTURE) begin
          if (!awaiting_fall) begin
            awaiting_fall = 1'b1;
          end else begin
            awaiting_fall = 1'b0;
            throttle = width_to_throttle(r.capture_value);
            if (armed) duty = throttle;
            else pulse_pending = 1'b1;
            advance = advance_for(duty);
          end
        end else begin
          if (pulse_pending) begin
            pulse_pending = 1'b0;
            arm_count = arm_count + 8'd1;
          end
          if (arm_count >= arm_ticks) begin
            arm_count = 8'd0;
            armed = 1'b1;
          end
          fault = tick_fault(r);
        end
      end
      s.throttle       = throttle;
      s.drive_duty     = (fault != FLT_NONE) ? 9'd0 : duty;
      s.advance_tenths = advance;
      s.armed          = armed;
      s.fault_code     = fault;
      s.drive_off      = (fault != FLT_NONE);
      owed_status.push_back(s);
    endfunction

    function int owed();
      return owed_status.size();
    endfunction

    function void same_field(string name, int want_v, int got_v);
      if (want_v != got_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      end
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (owed_status.size() == 0) begin
        mismatches++;
        $display("%0t: status with no request pending, expected none, actual %h",
                 $time, got);
        return;
      end
      want = owed_status.pop_front();
      same_field("throttle", int'(want.throttle), int'(got.throttle));
      same_field("drive_duty", int'(want.drive_duty), int'(got.drive_duty));
      same_field("advance_tenths", int'(want.advance_tenths), int'(got.advance_tenths));
      same_field("armed", int'(want.armed), int'(got.armed));
      same_field("fault_code", int'(want.fault_code), int'(got.fault_code));
      same_field("drive_off", int'(want.drive_off), int'(got.drive_off));
    endfunction
  endclass

endpackage

>>> tb/sv/tb_esc_throttle_pulse_and_fault_monitor_core.sv
// Bench top for esc_throttle_pulse_and_fault_monitor_core: directed and random
// capture/tick requests under varying limits and idling. Depends on esc_pkg,
// esc_tracker_pkg and the RTL of the block.
module tb_esc_throttle_pulse_and_fault_monitor_core;
  timeunit 1ns;
  timeprecision 1ps;

  import esc_pkg::*;
  import esc_tracker_pkg::*;

  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         SETTLE_CYCLES  = 4;
  localparam int         PHASE_ITEMS    = 310;
  localparam int         FROZEN_ITEMS   = 30;
  localparam logic [2:0] CFG_UNUSED_6   = 3'd6;
  localparam logic [2:0] CFG_UNUSED_7   = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic               clk;
  logic               rst_n              = 1'b0;
  logic               cfg_we             = 1'b0;
  logic [2:0]         cfg_index          = 3'd0;
  logic [11:0]        cfg_data           = 12'd0;
  logic               in_valid           = 1'b0;
  logic               in_stall;
  logic               in_mode            = MODE_CAPTURE;
  logic [15:0]        in_capture_value   = 16'd0;
  logic [11:0]        in_bus_voltage     = 12'd0;
  logic [11:0]        in_current_raw     = 12'd0;
  logic [15:0]        in_motor_speed     = 16'd0;
  logic signed [12:0] in_phase_a_current = 13'sd0;
  logic signed [12:0] in_phase_b_current = 13'sd0;
  logic signed [12:0] in_phase_c_current = 13'sd0;
  logic               out_valid;
  logic               out_stall          = 1'b0;
  logic [8:0]         out_throttle;
  logic [8:0]         out_drive_duty;
  logic [2:0]         out_advance_tenths;
  logic               out_armed;
  logic [2:0]         out_fault_code;
  logic               out_drive_off;

  int send_pct = 0;
  int recv_pct = 0;

  esc_status_tracker tracker;

  esc_throttle_pulse_and_fault_monitor_core #(.ADC_BITS(12)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_capture_value   (in_capture_value),
    .in_bus_voltage     (in_bus_voltage),
    .in_current_raw     (in_current_raw),
    .in_motor_speed     (in_motor_speed),
    .in_phase_a_current (in_phase_a_current),
    .in_phase_b_current (in_phase_b_current),
    .in_phase_c_current (in_phase_c_current),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_throttle       (out_throttle),
    .out_drive_duty     (out_drive_duty),
    .out_advance_tenths (out_advance_tenths),
    .out_armed          (out_armed),
    .out_fault_code     (out_fault_code),
    .out_drive_off      (out_drive_off)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_status(status_t'({out_throttle, out_drive_duty, out_advance_tenths,
                                      out_armed, out_fault_code, out_drive_off}));
  end

  function automatic esc_req_t any_request();
    esc_req_t r;
    r.mode          = 1'($urandom_range(0, 1));
    r.capture_value = 16'($urandom);
    r.bus_voltage   = 12'($urandom);
    r.current_raw   = 12'($urandom);
    r.motor_speed   = 16'($urandom);
    r.phase_a       = 13'($urandom);
    r.phase_b       = 13'($urandom);
    r.phase_c       = 13'($urandom);
    return r;
  endfunction

  function automatic esc_req_t capture(logic [15:0] w);
    esc_req_t r;
    r = any_request();
    r.mode = MODE_CAPTURE;
    r.capture_value = w;
    return r;
  endfunction

  // tick that stays clear of every enabled check, leaning on the limits
  function automatic esc_req_t safe_tick();
    esc_req_t r;
    int m;
    r = any_request();
    r.mode = MODE_TICK;
    if (tracker.prot_en[PEN_VOLT]) begin
      case ($urandom_range(0, 3))
        0: r.bus_voltage = tracker.under_volt;
        1: r.bus_voltage = tracker.over_volt;
        default: r.bus_voltage = 12'($urandom_range(tracker.under_volt, tracker.over_volt));
      endcase
    end
    if (tracker.prot_en[PEN_CUR])
      r.current_raw = ($urandom_range(0, 3) == 0) ? tracker.over_cur
                                                  : 12'($urandom_range(0, tracker.over_cur));
    if (tracker.prot_en[PEN_PHASE]) begin
      // all phases within a factor of two of each other
      m = $urandom_range(0, 2047);
      r.phase_a = 13'($urandom_range(m, 2 * m));
      r.phase_b = 13'($urandom_range(m, 2 * m));
      r.phase_c = 13'($urandom_range(m, 2 * m));
      if ($urandom_range(0, 3) == 0) begin
        r.phase_a = 13'(m);
        r.phase_b = 13'(2 * m);
      end
    end
    if ($urandom_range(0, 2) == 0) r.motor_speed = 16'($urandom_range(0, STALL_SPEED));
    if (tracker.tick_fault(r) == FLT_STALL)
      r.motor_speed = 16'($urandom_range(STALL_SPEED, 65535));
    return r;
  endfunction

  function automatic logic [15:0] pick_width();
    logic [15:0] w;
    case ($urandom_range(0, 9))
      0: w = 16'($urandom_range(0, 959));
      1: w = 16'($urandom_range(959, 961));
      2: w = 16'($urandom_range(960, 1399));
      3: begin
        case ($urandom_range(0, 3))
          0: w = 16'd1399;
          1: w = 16'd1400;
          2: w = 16'd2100;
          default: w = 16'd2101;
        endcase
      end
      4: w = 16'($urandom_range(1400, 65535));
      8: w = 16'($urandom_range(1215, 1230));  // duty around the stall threshold
      9: w = 16'($urandom);
      default: w = 16'($urandom_range(1015, 1075));  // advance bands
    endcase
    return w;
  endfunction

  task automatic set_idle(input idle_mode_e m);
    case (m)
      IDLE_NONE:     begin send_pct = 0;  recv_pct = 0;  end
      IDLE_SENDER:   begin send_pct = 60; recv_pct = 0;  end
      IDLE_RECEIVER: begin send_pct = 0;  recv_pct = 60; end
      default:       begin send_pct = 27; recv_pct = 27; end
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_req(input esc_req_t r);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_mode            <= r.mode;
    in_capture_value   <= r.capture_value;
    in_bus_voltage     <= r.bus_voltage;
    in_current_raw     <= r.current_raw;
    in_motor_speed     <= r.motor_speed;
    in_phase_a_current <= r.phase_a;
    in_phase_b_current <= r.phase_b;
    in_phase_c_current <= r.phase_c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_request(r);
    @(negedge clk);
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    while (tracker.owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [11:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic load_settings(input logic [11:0] ov, input logic [11:0] uv,
                               input logic [11:0] off, input logic [11:0] oc,
                               input logic [11:0] arm_d, input logic [11:0] pen_d);
    write_register(CFG_OVER_VOLT, ov);
    write_register(CFG_UNDER_VOLT, uv);
    write_register(CFG_CUR_OFFSET, off);
    write_register(CFG_OVER_CUR, oc);
    write_register(CFG_ARM_TICKS, arm_d);
    write_register(CFG_PROT_EN, pen_d);
    cfg_we <= 1'b0;
  endtask

  // mostly rise/fall/tick sequences, some loose requests that break the pairing
  task automatic run_phase(input int n);
    int done;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 99) < 80) begin
        if (!tracker.awaiting_fall) begin
          push_req(capture(16'($urandom)));
          done++;
        end
        push_req(capture(pick_width()));
        done++;
        repeat ($urandom_range(1, 3)) begin
          push_req(safe_tick());
          done++;
        end
      end else begin
        if ($urandom_range(0, 1)) push_req(safe_tick());
        else push_req(capture(pick_width()));
        done++;
      end
    end
  endtask

  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    esc_req_t   r;
    logic [2:0] flt_kind;
    logic [11:0] ov;
    tracker = new;
    set_idle(IDLE_NONE);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // writes to unused indexes must change nothing
    write_register(CFG_UNUSED_6, 12'($urandom));
    write_register(CFG_UNUSED_7, 12'($urandom));
    cfg_we <= 1'b0;

    // reset limits, not armed: throttle mapping edges only mark pulses pending
    push_req(safe_tick());
    push_req(capture(16'hFFFF));
    push_req(capture(16'd0));
    push_req(safe_tick());
    push_req(capture(16'd0));
    push_req(capture(16'd959));
    push_req(capture(16'd0));
    push_req(capture(16'd960));
    push_req(safe_tick());
    push_req(capture(16'd0));
    push_req(capture(16'd1400));
    push_req(capture(16'd0));
    push_req(capture(16'hFFFF));
    push_req(safe_tick());
    r = safe_tick();  // everything right at the limits, no fault
    r.bus_voltage = tracker.over_volt;
    r.current_raw = tracker.over_cur;
    r.phase_a = 13'sd1000;
    r.phase_b = 13'sd2000;
    r.phase_c = 13'sd2000;
    push_req(r);

    // threshold at or below the pending count arms on the next tick
    drain_requests();
    write_register(CFG_ARM_TICKS, 12'($urandom_range(0, 3)));
    cfg_we <= 1'b0;
    push_req(safe_tick());
    push_req(capture(16'd0));
    push_req(capture(16'd1020));
    push_req(capture(16'd0));
    push_req(capture(16'd1071));
    push_req(safe_tick());

    for (int p = 0; p < 6; p++) begin
      drain_requests();
      case (p)
        0: load_settings(12'd0, 12'd4095, 12'd4095, 12'd0,
                         {4'($urandom), 8'd255}, {8'($urandom), 4'd0});
        1: load_settings(12'd4095, 12'd0, 12'd0, 12'd4095, 12'd1, 12'd15);
        default: begin
          ov = 12'($urandom);
          load_settings(ov, 12'($urandom_range(0, ov)), 12'($urandom), 12'($urandom),
                        12'($urandom), 12'($urandom));
        end
      endcase
      set_idle(idle_mode_e'(p % 4));
      run_phase(PHASE_ITEMS);
    end

    // latch one fault, then everything after it must read back frozen
    drain_requests();
    load_settings(12'd3000, 12'd1000, 12'd0, 12'd2000, 12'(tracker.arm_ticks), 12'd15);
    set_idle(IDLE_BOTH);
    if (!tracker.awaiting_fall) push_req(capture(16'd0));
    push_req(capture(16'd2000));
    flt_kind = 3'($urandom_range(FLT_OVER_VOLT, FLT_PHASE));
    if (flt_kind == FLT_STALL && tracker.duty <= STALL_DUTY) flt_kind = FLT_PHASE;
    r = safe_tick();
    case (flt_kind)
      FLT_OVER_VOLT:  r.bus_voltage = 12'($urandom_range(3001, 4095));
      FLT_UNDER_VOLT: r.bus_voltage = 12'($urandom_range(0, 999));
      FLT_OVER_CUR:   r.current_raw = 12'($urandom_range(2001, 4095));
      FLT_STALL: begin
        r.current_raw = 12'($urandom_range(STALL_NET + 1, 2000));
        r.motor_speed = 16'($urandom_range(0, STALL_SPEED - 1));
      end
      default: begin
        r.phase_b = 13'($urandom_range(202, 4095));
        r.phase_a = 13'($urandom_range(0, r.phase_b / 2 - 1));
      end
    endcase
    push_req(r);
    repeat (FROZEN_ITEMS) push_req(any_request());

    drain_requests();
    if (tracker.mismatches == 0 && tracker.owed() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> esc_throttle_pulse_and_fault_monitor_core.f
rtl/core/esc_pkg.sv
rtl/core/esc_pulse.sv
rtl/core/esc_protect.sv
rtl/core/esc_obuf.sv
rtl/core/esc_throttle_pulse_and_fault_monitor_core.sv
tb/sv/esc_status_tracker_pkg.sv
tb/sv/tb_esc_throttle_pulse_and_fault_monitor_core.sv
